>>> hdl/aik_pkg.sv
package aik_pkg;

   // Field widths
   localparam int POS_W  = 20;
   localparam int LEN_W  = 19;
   localparam int ANG_W  = 16;
   localparam int STS_W  = 2;

   // Internal datapath widths
   localparam int SQ_W   = 40;   // squares and sums of squares
   localparam int RAD_W  = 60;   // square root radicands
   localparam int ROOT_W = 30;   // square root results
   localparam int NUM_W  = 62;   // law of cosines numerators, scaled
   localparam int CORD_W = 64;   // CORDIC operand width
   localparam int MAG_W  = 62;   // CORDIC operand magnitude width
   localparam int ACC_W  = 34;   // CORDIC vector and angle width
   localparam int TAB_W  = 32;

   // Status codes
   localparam logic [STS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STS_W-1:0] STATUS_RADIUS = 2'd1;
   localparam logic [STS_W-1:0] STATUS_REACH  = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_ONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TWO = 2'd1;

   localparam logic [LEN_W-1:0] LINK_ONE_RESET = 19'd8640;
   localparam logic [LEN_W-1:0] LINK_TWO_RESET = 19'd9408;

   // atan(2^-i) in units of pi/2^31
   localparam logic [TAB_W-1:0] ATAN_TAB [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // Operands carried alongside the square root pipeline
   typedef struct packed {
      logic signed [POS_W-1:0] y;
      logic [POS_W-1:0]        ax;
      logic signed [POS_W-1:0] z;
      logic signed [NUM_W-1:0] n1;
      logic signed [NUM_W-1:0] n2;
      logic [STS_W-1:0]        status;
      logic signed [ANG_W-1:0] rot;
   } aik_side_type;

   // Fields carried alongside the CORDIC pipeline
   typedef struct packed {
      logic [STS_W-1:0]        status;
      logic signed [ANG_W-1:0] rot;
   } aik_tail_type;

endpackage

>>> hdl/aik_isqrt.sv
module aik_isqrt #(
   parameter int IN_W   = 60,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [IN_W-1:0]       in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [IN_W/2-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int OUT_W = IN_W / 2;
   localparam int REM_W = OUT_W + 2;

   logic [IN_W-1:0]   rad_ff  [0:OUT_W];
   logic [IN_W-1:0]   rad_in  [0:OUT_W];
   logic [REM_W-1:0]  rem_ff  [0:OUT_W];
   logic [REM_W-1:0]  rem_in  [0:OUT_W];
   logic [OUT_W-1:0]  root_ff [0:OUT_W];
   logic [OUT_W-1:0]  root_in [0:OUT_W];
   logic [SIDE_W-1:0] side_ff [0:OUT_W];
   logic [SIDE_W-1:0] side_in [0:OUT_W];
   logic [OUT_W:0]    v_ff;
   logic [OUT_W:0]    v_in;

   // One result bit per stage, restoring digit recurrence
   always_comb begin
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      rad_in[0]  = in_rad;
      rem_in[0]  = '0;
      root_in[0] = '0;
      side_in[0] = in_side;
      for (int k = 1; k <= OUT_W; k++) begin
         cur   = {rem_ff[k-1], rad_ff[k-1][IN_W-1 -: 2]};
         trial = {2'b00, root_ff[k-1], 2'b01};
         rad_in[k]  = {rad_ff[k-1][IN_W-3:0], 2'b00};
         side_in[k] = side_ff[k-1];
         if (cur >= trial) begin
            rem_in[k]  = REM_W'(cur - trial);
            root_in[k] = {root_ff[k-1][OUT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[REM_W-1:0];
            root_in[k] = {root_ff[k-1][OUT_W-2:0], 1'b0};
         end
      end
   end

   assign v_in = {v_ff[OUT_W-1:0], in_valid};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= OUT_W; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = v_ff[OUT_W];
   assign out_root  = root_ff[OUT_W];
   assign out_side  = side_ff[OUT_W];

endmodule

>>> hdl/aik_cordic.sv
module aik_cordic #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [aik_pkg::CORD_W-1:0] in_y,
   input  logic signed [aik_pkg::CORD_W-1:0] in_x,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic signed [aik_pkg::ACC_W-1:0]  out_angle,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int CW     = aik_pkg::CORD_W;
   localparam int MW     = aik_pkg::MAG_W;
   localparam int VW     = aik_pkg::ACC_W;
   localparam int MANT_W = 31;
   localparam logic signed [VW-1:0] QUARTER = {{(VW-31){1'b0}}, 1'b1, 30'b0};

   function automatic logic [2*MW-1:0] norm_shift(input logic [MW-1:0] mx,
                                                  input logic [MW-1:0] my,
                                                  input int unsigned amt);
      logic [MW-1:0] both;
      both = mx | my;
      if ((both >> (MW - amt)) == '0) begin
         return {mx << amt, my << amt};
      end
      return {mx, my};
   endfunction

   // Capture signs and magnitudes
   logic [CW-1:0] mx_abs, my_abs;
   assign mx_abs = in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
   assign my_abs = in_y[CW-1] ? CW'(-in_y) : CW'(in_y);

   logic              s0_v_ff, s0_xn_ff, s0_yn_ff, s0_zero_ff;
   logic [MW-1:0]     s0_mx_ff, s0_my_ff;
   logic [SIDE_W-1:0] s0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_xn_ff   <= in_x[CW-1];
         s0_yn_ff   <= in_y[CW-1];
         s0_zero_ff <= (in_x == '0) && (in_y == '0);
         s0_mx_ff   <= mx_abs[MW-1:0];
         s0_my_ff   <= my_abs[MW-1:0];
         s0_side_ff <= in_side;
      end
   end

   // Left-justify the larger magnitude, two shift steps per stage
   logic [MW-1:0]     n_mx_ff [1:3];
   logic [MW-1:0]     n_my_ff [1:3];
   logic [MW-1:0]     n_mx_in [1:3];
   logic [MW-1:0]     n_my_in [1:3];
   logic [2*MW-1:0]   n_t1, n_t2, n_t3;
   logic [3:1]        n_v_ff, n_xn_ff, n_yn_ff, n_zero_ff;
   logic [SIDE_W-1:0] n_side_ff [1:3];

   always_comb begin
      n_t1 = norm_shift(s0_mx_ff, s0_my_ff, 32);
      {n_mx_in[1], n_my_in[1]} = norm_shift(n_t1[2*MW-1:MW], n_t1[MW-1:0], 16);
      n_t2 = norm_shift(n_mx_ff[1], n_my_ff[1], 8);
      {n_mx_in[2], n_my_in[2]} = norm_shift(n_t2[2*MW-1:MW], n_t2[MW-1:0], 4);
      n_t3 = norm_shift(n_mx_ff[2], n_my_ff[2], 2);
      {n_mx_in[3], n_my_in[3]} = norm_shift(n_t3[2*MW-1:MW], n_t3[MW-1:0], 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= '0;
      end else if (adv) begin
         n_v_ff <= {n_v_ff[2:1], s0_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= 3; k++) begin
            n_mx_ff[k] <= n_mx_in[k];
            n_my_ff[k] <= n_my_in[k];
         end
         n_xn_ff      <= {n_xn_ff[2:1], s0_xn_ff};
         n_yn_ff      <= {n_yn_ff[2:1], s0_yn_ff};
         n_zero_ff    <= {n_zero_ff[2:1], s0_zero_ff};
         n_side_ff[1] <= s0_side_ff;
         n_side_ff[2] <= n_side_ff[1];
         n_side_ff[3] <= n_side_ff[2];
      end
   end

   // Pre-rotate into the right half plane, then iterate
   logic [MANT_W-1:0]        mant_x, mant_y;
   logic signed [VW-1:0]     px, py;
   logic signed [VW-1:0]     vx_ff  [0:STAGES];
   logic signed [VW-1:0]     vx_in  [0:STAGES];
   logic signed [VW-1:0]     vy_ff  [0:STAGES];
   logic signed [VW-1:0]     vy_in  [0:STAGES];
   logic signed [VW-1:0]     ang_ff [0:STAGES];
   logic signed [VW-1:0]     ang_in [0:STAGES];
   logic [SIDE_W-1:0]        it_side_ff [0:STAGES];
   logic [SIDE_W-1:0]        it_side_in [0:STAGES];
   logic [STAGES:0]          it_zero_ff, it_v_ff;

   assign mant_x = n_mx_ff[3][MW-1 -: MANT_W];
   assign mant_y = n_my_ff[3][MW-1 -: MANT_W];

   always_comb begin
      logic signed [VW-1:0] sx;
      logic signed [VW-1:0] sy;
      logic signed [VW-1:0] step;
      px = n_xn_ff[3] ? -$signed({{(VW-MANT_W){1'b0}}, mant_x})
                      :  $signed({{(VW-MANT_W){1'b0}}, mant_x});
      py = n_yn_ff[3] ? -$signed({{(VW-MANT_W){1'b0}}, mant_y})
                      :  $signed({{(VW-MANT_W){1'b0}}, mant_y});
      if (px < 0) begin
         if (py >= 0) begin
            vx_in[0]  = py;
            vy_in[0]  = -px;
            ang_in[0] = QUARTER;
         end else begin
            vx_in[0]  = -py;
            vy_in[0]  = px;
            ang_in[0] = -QUARTER;
         end
      end else begin
         vx_in[0]  = px;
         vy_in[0]  = py;
         ang_in[0] = '0;
      end
      it_side_in[0] = n_side_ff[3];
      for (int k = 1; k <= STAGES; k++) begin
         sx   = vx_ff[k-1] >>> (k - 1);
         sy   = vy_ff[k-1] >>> (k - 1);
         step = $signed({{(VW-aik_pkg::TAB_W){1'b0}}, aik_pkg::ATAN_TAB[k-1]});
         if (vy_ff[k-1] > 0) begin
            vx_in[k]  = vx_ff[k-1] + sy;
            vy_in[k]  = vy_ff[k-1] - sx;
            ang_in[k] = ang_ff[k-1] + step;
         end else begin
            vx_in[k]  = vx_ff[k-1] - sy;
            vy_in[k]  = vy_ff[k-1] + sx;
            ang_in[k] = ang_ff[k-1] - step;
         end
         it_side_in[k] = it_side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         it_v_ff <= '0;
      end else if (adv) begin
         it_v_ff <= {it_v_ff[STAGES-1:0], n_v_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= STAGES; k++) begin
            vx_ff[k]      <= vx_in[k];
            vy_ff[k]      <= vy_in[k];
            ang_ff[k]     <= ang_in[k];
            it_side_ff[k] <= it_side_in[k];
         end
         it_zero_ff <= {it_zero_ff[STAGES-1:0], n_zero_ff[3]};
      end
   end

   assign out_valid = it_v_ff[STAGES];
   assign out_angle = it_zero_ff[STAGES] ? '0 : ang_ff[STAGES];
   assign out_side  = it_side_ff[STAGES];

endmodule

>>> hdl/arm_inverse_kinematics_top.sv
// Inverse kinematics for a two-link arm on a yawing base. Each accepted target point
// (x, y, z in 1/64 mm) and end rotation yields one result with base, shoulder and elbow
// angles (LSB pi/32768 rad) plus a status; on a zero horizontal radius or an unreachable
// point the status is set and all joint angles are zero. The pipeline takes one item per
// cycle while no result is held, with three setup stages for squares and reach checks, 31
// stages of the bit-per-stage square roots, one product stage, the CORDIC (capture, three
// normalize stages, pre-rotation, CORDIC_STAGES iterations) and an output register. A held
// result freezes the whole pipeline, so req_stall follows rsp_stall while a result is
// waiting. Link lengths are to be written on the csr port only while the block is idle
// (not enforced by the block); csr_ready is always high and other indexes are ignored.
module arm_inverse_kinematics_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [aik_pkg::POS_W-1:0]           req_target_x,
   input  logic signed [aik_pkg::POS_W-1:0]           req_target_y,
   input  logic signed [aik_pkg::POS_W-1:0]           req_target_z,
   input  logic signed [aik_pkg::ANG_W-1:0]           req_end_rotation,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [aik_pkg::ANG_W-1:0]           rsp_base_angle,
   output logic signed [aik_pkg::ANG_W-1:0]           rsp_shoulder_angle,
   output logic signed [aik_pkg::ANG_W-1:0]           rsp_elbow_angle,
   output logic signed [aik_pkg::ANG_W-1:0]           rsp_rotation_out,
   output logic [aik_pkg::STS_W-1:0]                  rsp_status,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [aik_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [aik_pkg::LEN_W-1:0]                  csr_data
);

   localparam int PW = aik_pkg::POS_W;
   localparam int LW = aik_pkg::LEN_W;
   localparam int QW = aik_pkg::SQ_W;
   localparam int CW = aik_pkg::CORD_W;
   localparam int NW = aik_pkg::NUM_W;
   localparam int RW = aik_pkg::ROOT_W;
   localparam int AW = aik_pkg::ANG_W;
   localparam int SIDE_W = $bits(aik_pkg::aik_side_type);
   localparam int TAIL_W = $bits(aik_pkg::aik_tail_type);

   logic adv;
   logic rsp_valid_ff;

   // Freeze everything while the output register holds an untaken result
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Link length registers
   logic [LW-1:0] link_one_ff, link_two_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_one_ff <= aik_pkg::LINK_ONE_RESET;
         link_two_ff <= aik_pkg::LINK_TWO_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            aik_pkg::CSR_LINK_ONE: link_one_ff <= csr_data;
            aik_pkg::CSR_LINK_TWO: link_two_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage A: squares of the inputs and link terms
   logic signed [2*PW-1:0] x_sq, y_sq, z_sq;
   logic [LW:0]            len_sum;
   logic [LW-1:0]          len_dif;
   logic [PW-1:0]          ax_in;

   assign x_sq    = req_target_x * req_target_x;
   assign y_sq    = req_target_y * req_target_y;
   assign z_sq    = req_target_z * req_target_z;
   assign len_sum = {1'b0, link_one_ff} + {1'b0, link_two_ff};
   assign len_dif = (link_one_ff > link_two_ff) ? link_one_ff - link_two_ff
                                                : link_two_ff - link_one_ff;
   assign ax_in   = req_target_x[PW-1] ? PW'(-req_target_x) : PW'(req_target_x);

   logic                a_v_ff;
   logic [QW-1:0]       a_x2_ff, a_y2_ff, a_z2_ff, a_l1sq_ff, a_l2sq_ff, a_sum2_ff, a_dif2_ff;
   logic                a_lz_ff;
   logic signed [PW-1:0] a_y_ff, a_z_ff;
   logic [PW-1:0]       a_ax_ff;
   logic signed [AW-1:0] a_rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_x2_ff   <= QW'(x_sq);
         a_y2_ff   <= QW'(y_sq);
         a_z2_ff   <= QW'(z_sq);
         a_l1sq_ff <= QW'(link_one_ff * link_one_ff);
         a_l2sq_ff <= QW'(link_two_ff * link_two_ff);
         a_sum2_ff <= QW'(len_sum * len_sum);
         a_dif2_ff <= QW'(len_dif * len_dif);
         a_lz_ff   <= (link_one_ff == '0) || (link_two_ff == '0);
         a_y_ff    <= req_target_y;
         a_z_ff    <= req_target_z;
         a_ax_ff   <= ax_in;
         a_rot_ff  <= req_end_rotation;
      end
   end

   // Stage B: horizontal radius and distance squared
   logic                 b_v_ff, b_lz_ff;
   logic [QW-1:0]        b_r2_ff, b_d2_ff, b_l1sq_ff, b_l2sq_ff, b_sum2_ff, b_dif2_ff;
   logic signed [PW-1:0] b_y_ff, b_z_ff;
   logic [PW-1:0]        b_ax_ff;
   logic signed [AW-1:0] b_rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_r2_ff   <= a_x2_ff + a_y2_ff;
         b_d2_ff   <= a_x2_ff + a_y2_ff + a_z2_ff;
         b_l1sq_ff <= a_l1sq_ff;
         b_l2sq_ff <= a_l2sq_ff;
         b_sum2_ff <= a_sum2_ff;
         b_dif2_ff <= a_dif2_ff;
         b_lz_ff   <= a_lz_ff;
         b_y_ff    <= a_y_ff;
         b_z_ff    <= a_z_ff;
         b_ax_ff   <= a_ax_ff;
         b_rot_ff  <= a_rot_ff;
      end
   end

   // Stage C: status, radicands and scaled numerators
   logic [aik_pkg::STS_W-1:0] status_in;
   logic signed [QW+1:0]      n1_raw, n2_raw;

   always_comb begin
      priority if (b_r2_ff == '0) begin
         status_in = aik_pkg::STATUS_RADIUS;
      end else if (b_lz_ff || (b_d2_ff > b_sum2_ff) || (b_d2_ff < b_dif2_ff)) begin
         status_in = aik_pkg::STATUS_REACH;
      end else begin
         status_in = aik_pkg::STATUS_OK;
      end
   end

   assign n1_raw = $signed({2'b00, b_d2_ff}) + $signed({2'b00, b_l1sq_ff})
                 - $signed({2'b00, b_l2sq_ff});
   assign n2_raw = $signed({2'b00, b_d2_ff}) + $signed({2'b00, b_l2sq_ff})
                 - $signed({2'b00, b_l1sq_ff});

   logic                       c_v_ff;
   logic [aik_pkg::RAD_W-1:0]  c_rad_r_ff, c_rad_lo_ff, c_rad_hi_ff;
   aik_pkg::aik_side_type      c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_rad_r_ff       <= {b_r2_ff, 20'b0};
         c_rad_lo_ff      <= {QW'(b_d2_ff - b_dif2_ff), 20'b0};
         c_rad_hi_ff      <= {QW'(b_sum2_ff - b_d2_ff), 20'b0};
         c_side_ff.y      <= b_y_ff;
         c_side_ff.ax     <= b_ax_ff;
         c_side_ff.z      <= b_z_ff;
         c_side_ff.n1     <= {n1_raw, 20'b0};
         c_side_ff.n2     <= {n2_raw, 20'b0};
         c_side_ff.status <= status_in;
         c_side_ff.rot    <= b_rot_ff;
      end
   end

   // Square roots of the radius and of the two reach factors
   logic              sq_r_v, sq_lo_v, sq_hi_v;
   logic [RW-1:0]     root_r, root_lo, root_hi;
   logic [SIDE_W-1:0] sq_side;
   aik_pkg::aik_side_type sq_side_s;

   aik_isqrt #(.IN_W(aik_pkg::RAD_W), .SIDE_W(SIDE_W)) u_sqrt_r (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(c_v_ff), .in_rad(c_rad_r_ff), .in_side(c_side_ff),
      .out_valid(sq_r_v), .out_root(root_r), .out_side(sq_side)
   );

   aik_isqrt #(.IN_W(aik_pkg::RAD_W), .SIDE_W(1)) u_sqrt_lo (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(c_v_ff), .in_rad(c_rad_lo_ff), .in_side(1'b0),
      .out_valid(sq_lo_v), .out_root(root_lo), .out_side()
   );

   aik_isqrt #(.IN_W(aik_pkg::RAD_W), .SIDE_W(1)) u_sqrt_hi (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(c_v_ff), .in_rad(c_rad_hi_ff), .in_side(1'b0),
      .out_valid(sq_hi_v), .out_root(root_hi), .out_side()
   );

   assign sq_side_s = sq_side;

   // Product stage: sine term of both law of cosines angles
   logic                  m_v_ff;
   logic [2*RW-1:0]       m_s_ff;
   logic [RW-1:0]         m_rr_ff;
   aik_pkg::aik_side_type m_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= sq_r_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_s_ff    <= root_lo * root_hi;
         m_rr_ff   <= root_r;
         m_side_ff <= sq_side_s;
      end
   end

   // CORDIC operands
   logic signed [CW-1:0] base_y, base_x, az_y, az_x, a1_y, a1_x, a2_x;
   aik_pkg::aik_tail_type m_tail;

   assign base_y = {{(CW-PW){m_side_ff.y[PW-1]}}, m_side_ff.y};
   assign base_x = {{(CW-PW){1'b0}}, m_side_ff.ax};
   assign az_y   = {{(CW-PW-10){m_side_ff.z[PW-1]}}, m_side_ff.z, 10'b0};
   assign az_x   = {{(CW-RW){1'b0}}, m_rr_ff};
   assign a1_y   = {{(CW-2*RW){1'b0}}, m_s_ff};
   assign a1_x   = {{(CW-NW){m_side_ff.n1[NW-1]}}, m_side_ff.n1};
   assign a2_x   = {{(CW-NW){m_side_ff.n2[NW-1]}}, m_side_ff.n2};
   assign m_tail.status = m_side_ff.status;
   assign m_tail.rot    = m_side_ff.rot;

   logic                             cb_v, cz_v, c1_v, c2_v;
   logic signed [aik_pkg::ACC_W-1:0] ang_base, ang_z, ang_1, ang_2;
   logic [TAIL_W-1:0]                tail_out;
   aik_pkg::aik_tail_type            tail_s;

   aik_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(TAIL_W)) u_cordic_base (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(m_v_ff), .in_y(base_y), .in_x(base_x), .in_side(m_tail),
      .out_valid(cb_v), .out_angle(ang_base), .out_side(tail_out)
   );

   aik_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_z (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(m_v_ff), .in_y(az_y), .in_x(az_x), .in_side(1'b0),
      .out_valid(cz_v), .out_angle(ang_z), .out_side()
   );

   aik_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_one (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(m_v_ff), .in_y(a1_y), .in_x(a1_x), .in_side(1'b0),
      .out_valid(c1_v), .out_angle(ang_1), .out_side()
   );

   aik_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_two (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(m_v_ff), .in_y(a1_y), .in_x(a2_x), .in_side(1'b0),
      .out_valid(c2_v), .out_angle(ang_2), .out_side()
   );

   assign tail_s = tail_out;

   // Output register: combine angles and round to the output angle LSB
   logic [31:0]   base_sum, sh_sum, el_sum;
   logic          ok;
   logic [AW-1:0] base_in, sh_in, el_in;

   assign base_sum = ang_base[31:0] + 32'h0000_8000;
   assign sh_sum   = 32'h4000_0000 - ang_z[31:0] - ang_1[31:0] + 32'h0000_8000;
   assign el_sum   = ang_2[31:0] - ang_z[31:0] + 32'h0000_8000;
   assign ok       = (tail_s.status == aik_pkg::STATUS_OK);
   assign base_in  = ok ? base_sum[31:16] : '0;
   assign sh_in    = ok ? sh_sum[31:16] : '0;
   assign el_in    = ok ? el_sum[31:16] : '0;

   logic [AW-1:0]             base_ff, sh_ff, el_ff, rot_ff;
   logic [aik_pkg::STS_W-1:0] status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cb_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base_ff   <= base_in;
         sh_ff     <= sh_in;
         el_ff     <= el_in;
         rot_ff    <= tail_s.rot;
         status_ff <= tail_s.status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_base_angle     = base_ff;
   assign rsp_shoulder_angle = sh_ff;
   assign rsp_elbow_angle    = el_ff;
   assign rsp_rotation_out   = rot_ff;
   assign rsp_status         = status_ff;

   // Failed solutions carry zero joint angles
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != aik_pkg::STATUS_OK) |->
         (rsp_base_angle == '0) && (rsp_shoulder_angle == '0) && (rsp_elbow_angle == '0))
      else $error("joint angles not zero on failed solution");

   // Input stalls only while a result waits at the output
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // Parallel square root lanes stay aligned
   a_sqrt_align: assert property (@(posedge clock) disable iff (reset)
      (sq_r_v == sq_lo_v) && (sq_r_v == sq_hi_v))
      else $error("square root lanes out of step");

   // Parallel CORDIC lanes stay aligned
   a_cordic_align: assert property (@(posedge clock) disable iff (reset)
      (cb_v == cz_v) && (cb_v == c1_v) && (cb_v == c2_v))
      else $error("CORDIC lanes out of step");

endmodule

>>> tb/sv/arm_inverse_kinematics_top_tb.sv
`timescale 1ns / 1ps

module arm_inverse_kinematics_top_tb;

   localparam int STAGES     = 16;
   localparam int LATENCY    = STAGES + 41;
   localparam int WDOG_LIMIT = 6000;
   localparam int HOLD_LEN   = 300;

   // Indexes past the two link registers, written to check they are ignored
   localparam logic [aik_pkg::CSR_IDX_W-1:0] CSR_SPARE_TWO   = 2'd2;
   localparam logic [aik_pkg::CSR_IDX_W-1:0] CSR_SPARE_THREE = 2'd3;

   // Joint angle predictor and the queue of joint sets still owed by the block
   class ik_scoreboard;
      typedef struct {
         logic [aik_pkg::ANG_W-1:0] base;
         logic [aik_pkg::ANG_W-1:0] shoulder;
         logic [aik_pkg::ANG_W-1:0] elbow;
         logic [aik_pkg::ANG_W-1:0] rot;
         logic [aik_pkg::STS_W-1:0] status;
      } joint_set_type;

      joint_set_type    joints_q[$];
      int               errors;
      longint unsigned  link_one;
      longint unsigned  link_two;

      function new();
         errors   = 0;
         link_one = aik_pkg::LINK_ONE_RESET;
         link_two = aik_pkg::LINK_TWO_RESET;
      endfunction

      function void set_link(logic [aik_pkg::CSR_IDX_W-1:0] idx,
                             logic [aik_pkg::LEN_W-1:0] val);
         if (idx == aik_pkg::CSR_LINK_ONE) link_one = val;
         else if (idx == aik_pkg::CSR_LINK_TWO) link_two = val;
      endfunction

      function int pending();
         return joints_q.size();
      endfunction

      static function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // Vectoring CORDIC, angle in units of pi/2^31
      static function longint atan2_fix(longint y, longint x);
         longint unsigned my, mx, big;
         longint vx, vy, ang, t, sx, sy;
         int n;
         my  = (y < 0) ? 64'(-y) : 64'(y);
         mx  = (x < 0) ? 64'(-x) : 64'(x);
         ang = 0;
         big = (mx > my) ? mx : my;
         if (big == 0) return 0;
         while (big >= (64'd1 << 31)) begin
            big = big >> 1; mx = mx >> 1; my = my >> 1;
         end
         while (big < (64'd1 << 30)) begin
            big = big << 1; mx = mx << 1; my = my << 1;
         end
         vx = (x < 0) ? -longint'(mx) : longint'(mx);
         vy = (y < 0) ? -longint'(my) : longint'(my);
         // rotate left half plane into the right one
         if (vx < 0) begin
            if (vy >= 0) begin
               t = vx; vx = vy; vy = -t; ang = longint'(1) << 30;
            end else begin
               t = vx; vx = -vy; vy = t; ang = -(longint'(1) << 30);
            end
         end
         n = (STAGES > 32) ? 32 : STAGES;
         for (int i = 0; i < n; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
               vx = vx + sy; vy = vy - sx; ang = ang + longint'(aik_pkg::ATAN_TAB[i]);
            end else begin
               vx = vx - sy; vy = vy + sx; ang = ang - longint'(aik_pkg::ATAN_TAB[i]);
            end
         end
         return ang;
      endfunction

      static function logic [aik_pkg::ANG_W-1:0] to_binary_angle(longint a);
         longint q;
         q = (a + 32768) >>> 16;
         return q[aik_pkg::ANG_W-1:0];
      endfunction

      // Predict the joint set of one accepted target
      function void note_target(logic signed [aik_pkg::POS_W-1:0] tx,
                                logic signed [aik_pkg::POS_W-1:0] ty,
                                logic signed [aik_pkg::POS_W-1:0] tz,
                                logic [aik_pkg::ANG_W-1:0] rot);
         joint_set_type e;
         longint x, y, z, rr, az, base, s, n1, n2, a1, a2;
         longint unsigned r2, d2, sum2, dif, dif2;
         x = tx; y = ty; z = tz;
         r2   = 64'(x * x) + 64'(y * y);
         d2   = r2 + 64'(z * z);
         sum2 = (link_one + link_two) * (link_one + link_two);
         dif  = (link_one > link_two) ? link_one - link_two : link_two - link_one;
         dif2 = dif * dif;
         e.base = 0; e.shoulder = 0; e.elbow = 0; e.rot = rot;
         if (r2 == 0) begin
            e.status = aik_pkg::STATUS_RADIUS;
         end else if (link_one == 0 || link_two == 0 || d2 > sum2 || d2 < dif2) begin
            e.status = aik_pkg::STATUS_REACH;
         end else begin
            rr   = longint'(int_sqrt(r2 << 20));
            az   = atan2_fix(z * 1024, rr);
            base = atan2_fix(y, (x < 0) ? -x : x);
            s    = longint'(int_sqrt((d2 - dif2) << 20) * int_sqrt((sum2 - d2) << 20));
            n1   = (longint'(d2) + longint'(link_one * link_one)
                    - longint'(link_two * link_two)) * (longint'(1) << 20);
            n2   = (longint'(d2) + longint'(link_two * link_two)
                    - longint'(link_one * link_one)) * (longint'(1) << 20);
            a1   = atan2_fix(s, n1);
            a2   = atan2_fix(s, n2);
            e.base     = to_binary_angle(base);
            e.shoulder = to_binary_angle((longint'(1) << 30) - az - a1);
            e.elbow    = to_binary_angle(a2 - az);
            e.status   = aik_pkg::STATUS_OK;
         end
         joints_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [aik_pkg::ANG_W-1:0] exp_v,
                                  logic [aik_pkg::ANG_W-1:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_joints(logic [aik_pkg::ANG_W-1:0] base,
                                 logic [aik_pkg::ANG_W-1:0] shoulder,
                                 logic [aik_pkg::ANG_W-1:0] elbow,
                                 logic [aik_pkg::ANG_W-1:0] rot,
                                 logic [aik_pkg::STS_W-1:0] status);
         joint_set_type e;
         if (joints_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual base %h status %0d",
                     $time, base, status);
            return;
         end
         e = joints_q.pop_front();
         compare_field("status", 16'(e.status), 16'(status));
         compare_field("base_angle", e.base, base);
         compare_field("shoulder_angle", e.shoulder, shoulder);
         compare_field("elbow_angle", e.elbow, elbow);
         compare_field("rotation_out", e.rot, rot);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [aik_pkg::POS_W-1:0] req_target_x = '0;
   logic signed [aik_pkg::POS_W-1:0] req_target_y = '0;
   logic signed [aik_pkg::POS_W-1:0] req_target_z = '0;
   logic signed [aik_pkg::ANG_W-1:0] req_end_rotation = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [aik_pkg::ANG_W-1:0] rsp_base_angle, rsp_shoulder_angle, rsp_elbow_angle;
   logic signed [aik_pkg::ANG_W-1:0] rsp_rotation_out;
   logic [aik_pkg::STS_W-1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [aik_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [aik_pkg::LEN_W-1:0] csr_data = '0;

   ik_scoreboard joints_sb = new();
   int  idle_pct = 34;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int  hold_cnt = 0;
   int  quiet_cycles = 0;

   arm_inverse_kinematics_top #(.CORDIC_STAGES(STAGES)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Note each accepted target
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         joints_sb.note_target(req_target_x, req_target_y, req_target_z, req_end_rotation);
   end

   // Check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         joints_sb.check_joints(rsp_base_angle, rsp_shoulder_angle, rsp_elbow_angle,
                                rsp_rotation_out, rsp_status);
   end

   // Receiver: random stall plus one long hold-off
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= hold_cnt - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_done <= 1'b1;
         hold_cnt  <= HOLD_LEN;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_LIMIT) begin
         $display("arm_inverse_kinematics_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_target(logic signed [aik_pkg::POS_W-1:0] x,
                              logic signed [aik_pkg::POS_W-1:0] y,
                              logic signed [aik_pkg::POS_W-1:0] z,
                              logic signed [aik_pkg::ANG_W-1:0] r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_target_x     <= x;
      req_target_y     <= y;
      req_target_z     <= z;
      req_end_rotation <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (joints_sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_link(logic [aik_pkg::CSR_IDX_W-1:0] idx,
                             logic [aik_pkg::LEN_W-1:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      joints_sb.set_link(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [aik_pkg::POS_W-1:0] coord_within(longint h);
      if (h > 524287) h = 524287;
      return aik_pkg::POS_W'(longint'($urandom_range(32'(2 * h))) - h);
   endfunction

   // Mostly reachable targets, some zero radius, some over a doubled range and full-range noise
   task automatic random_targets(int count);
      longint h;
      int kind;
      logic signed [aik_pkg::POS_W-1:0] x, y, z;
      for (int i = 0; i < count; i++) begin
         h    = longint'(joints_sb.link_one + joints_sb.link_two) / 2;
         kind = $urandom_range(99);
         if (h < 1) h = 1;
         if (kind < 65) begin
            x = coord_within(h); y = coord_within(h); z = coord_within(h);
         end else if (kind < 75) begin
            x = 0; y = 0; z = aik_pkg::POS_W'($urandom);
         end else if (kind < 85) begin
            x = coord_within(2 * h); y = coord_within(2 * h); z = coord_within(2 * h);
         end else begin
            x = aik_pkg::POS_W'($urandom);
            y = aik_pkg::POS_W'($urandom);
            z = aik_pkg::POS_W'($urandom);
         end
         send_target(x, y, z, aik_pkg::ANG_W'($urandom));
         if (i == count / 3) hold_go <= 1'b1;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed targets at reset link lengths
      send_target(0, 0, 0, 16'sh7FFF);
      send_target(0, 0, 20'sh7FFFF, 16'sh8000);
      send_target(18048, 0, 0, 0);
      send_target(18049, 0, 0, 1);
      send_target(768, 0, 0, 2);
      send_target(767, 0, 0, 3);
      send_target(-18048, 0, 0, 4);
      send_target(0, 18048, 0, 5);
      send_target(0, -18048, 0, 6);
      send_target(100, 0, 18000, 7);
      send_target(100, 0, -18000, 8);
      send_target(-9000, -9000, 5000, 9);
      send_target(-9000, 9000, -5000, 10);
      send_target(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, -1);
      send_target(20'sh80000, 20'sh80000, 20'sh80000, 16'sh4000);
      send_target(1, 0, 0, 11);
      send_target(10000, 1, 0, 12);
      send_target(10000, -1, 0, 13);
      send_target(-1, 0, 0, 14);

      random_targets(250);

      // Extremes and mixed link lengths, including zero
      write_link(aik_pkg::CSR_LINK_ONE, 19'd1);
      write_link(aik_pkg::CSR_LINK_TWO, 19'd1);
      send_target(2, 0, 0, 0);
      send_target(1, 1, 0, 0);
      send_target(0, 1, 1, 0);
      random_targets(120);
      drain_results();
      random_targets(120);

      write_link(aik_pkg::CSR_LINK_ONE, 19'h7FFFF);
      write_link(aik_pkg::CSR_LINK_TWO, 19'h7FFFF);
      idle_pct = 0;
      random_targets(260);
      idle_pct = 34;

      write_link(aik_pkg::CSR_LINK_ONE, 19'd0);
      write_link(aik_pkg::CSR_LINK_TWO, 19'd9408);
      random_targets(150);

      write_link(aik_pkg::CSR_LINK_ONE, 19'h7FFFF);
      write_link(aik_pkg::CSR_LINK_TWO, 19'd1);
      random_targets(260);

      write_link(aik_pkg::CSR_LINK_ONE, aik_pkg::LEN_W'($urandom_range(1, 200000)));
      write_link(aik_pkg::CSR_LINK_TWO, aik_pkg::LEN_W'($urandom_range(1, 200000)));
      write_link(CSR_SPARE_TWO, 19'd5);
      write_link(CSR_SPARE_THREE, 19'h7FFFF);
      random_targets(260);

      write_link(aik_pkg::CSR_LINK_ONE, aik_pkg::LINK_ONE_RESET);
      write_link(aik_pkg::CSR_LINK_TWO, aik_pkg::LINK_TWO_RESET);
      random_targets(260);

      drain_results();
      if (joints_sb.errors == 0 && joints_sb.pending() == 0) begin
         $display("arm_inverse_kinematics_top_tb OK");
      end else begin
         $display("arm_inverse_kinematics_top_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/aik_pkg.sv
hdl/aik_isqrt.sv
hdl/aik_cordic.sv
hdl/arm_inverse_kinematics_top.sv
tb/sv/arm_inverse_kinematics_top_tb.sv
